[rtl/eip_pkg.sv]
// ----------------------------------------------------------------------------
// Ethernet IPv4 header parser package
// Shared constants, status codes and the types passed between the capture,
// summary and top-level modules.
// ----------------------------------------------------------------------------
package eip_pkg;

	localparam int unsigned MAX_CAPTURE_DEF = 262144;

	localparam logic [15:0] TYPE_VLAN = 16'h8100;
	localparam logic [15:0] TYPE_QINQ = 16'h88a8;
	localparam logic [15:0] TYPE_IPV4 = 16'h0800;
	localparam logic [15:0] TYPE_ARP  = 16'h0806;

	localparam logic [7:0] IP_MIN_HDR = 8'd20;
	localparam logic [7:0] TCP_MIN_HDR = 8'd20;
	localparam logic [7:0] SMALL_L4_HDR = 8'd8;
	localparam logic [7:0] ETH_HDR = 8'd14;
	localparam logic [7:0] VLAN_HDR = 8'd18;
	localparam logic [7:0] ARP_MIN = 8'd8;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [3:0] ST_L4_OK      = 4'd0;
	localparam logic [3:0] ST_OTHER_PROTO = 4'd1;
	localparam logic [3:0] ST_ARP        = 4'd2;
	localparam logic [3:0] ST_OTHER_TYPE = 4'd3;
	localparam logic [3:0] ST_SHORT_ETH  = 4'd4;
	localparam logic [3:0] ST_SHORT_VLAN = 4'd5;
	localparam logic [3:0] ST_SHORT_IP   = 4'd6;
	localparam logic [3:0] ST_NOT_V4     = 4'd7;
	localparam logic [3:0] ST_BAD_IHL    = 4'd8;
	localparam logic [3:0] ST_SHORT_L4   = 4'd9;
	localparam logic [3:0] ST_BAD_TCP_OFF = 4'd10;
	localparam logic [3:0] ST_BAD_UDP_LEN = 4'd11;
	localparam logic [3:0] ST_SHORT_ARP  = 4'd12;

	localparam int unsigned OUT_W = 176;

	typedef struct packed {
		logic [15:0] frame_type;
		logic        tag_seen;
		logic [7:0]  version_ihl;
		logic [15:0] ip_total_len;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] port_a;
		logic [15:0] port_b;
		logic [15:0] l4_len_word;
		logic [7:0]  flag;
	} frame_t;

	typedef struct packed {
		logic [15:0] payload_length;
		logic [7:0]  payload_offset;
		logic [15:0] icmp_kind;
		logic [7:0]  tcp_flag_bits;
		logic [15:0] dest_port;
		logic [15:0] source_port;
		logic [31:0] dest_addr;
		logic [31:0] source_addr;
		logic [7:0]  ip_protocol;
		logic [15:0] l2_type;
		logic [3:0]  status;
	} result_t;

endpackage

[rtl/eip_capture.sv]
// ----------------------------------------------------------------------------
// Header field capture
// Tracks the byte position in the frame and captures the ethertype, the IPv4
// header fields and the first words of the L4 header as bytes stream past.
// ----------------------------------------------------------------------------
module eip_capture #(
	parameter int unsigned MAX_CAPTURE = eip_pkg::MAX_CAPTURE_DEF,
	parameter int unsigned CNT_W = $clog2(MAX_CAPTURE + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                last,
	input  logic [7:0]          data,
	output eip_pkg::frame_t     frame_nxt,
	output logic [CNT_W-1:0]    count_nxt
);

	localparam int unsigned PW = (CNT_W > 8) ? CNT_W : 8;

	eip_pkg::frame_t  frame_q;
	logic [CNT_W-1:0] count_q;

	always_comb begin
		logic [PW-1:0] pos;
		logic [PW-1:0] hdr;
		logic [PW-1:0] l4_pos;
		logic [PW-1:0] rel;
		logic [7:0]    ihl;
		logic [15:0]   type_word;
		frame_nxt = frame_q;
		count_nxt = count_q;
		pos = PW'(count_q);
		hdr = frame_q.tag_seen ? PW'(eip_pkg::VLAN_HDR) : PW'(eip_pkg::ETH_HDR);
		ihl = {2'b00, frame_q.version_ihl[3:0], 2'b00};
		l4_pos = hdr + PW'(ihl);
		rel = '0;
		type_word = {frame_q.frame_type[7:0], data};
		if (count_q < CNT_W'(MAX_CAPTURE)) begin
			count_nxt = count_q + 1'b1;
			if (pos == PW'(12) || pos == PW'(13)) begin
				frame_nxt.frame_type = type_word;
				if (pos == PW'(13) &&
				    (type_word == eip_pkg::TYPE_VLAN || type_word == eip_pkg::TYPE_QINQ)) begin
					frame_nxt.tag_seen = 1'b1;
				end
			end else if (frame_q.tag_seen && pos == PW'(16)) begin
				frame_nxt.flag = data;
			end else if (frame_q.tag_seen && pos == PW'(17)) begin
				frame_nxt.frame_type = {frame_q.flag, data};
				frame_nxt.flag = '0;
			end else if (pos >= hdr && frame_q.frame_type == eip_pkg::TYPE_IPV4) begin
				if (pos < hdr + PW'(eip_pkg::IP_MIN_HDR)) begin
					rel = pos - hdr;
					if (rel == PW'(0)) begin
						frame_nxt.version_ihl = data;
					end else if (rel == PW'(2) || rel == PW'(3)) begin
						frame_nxt.ip_total_len = {frame_q.ip_total_len[7:0], data};
					end else if (rel == PW'(9)) begin
						frame_nxt.proto = data;
					end else if (rel >= PW'(12) && rel < PW'(16)) begin
						frame_nxt.src = {frame_q.src[23:0], data};
					end else if (rel >= PW'(16)) begin
						frame_nxt.dst = {frame_q.dst[23:0], data};
					end
				end else if (ihl >= eip_pkg::IP_MIN_HDR && pos >= l4_pos) begin
					rel = pos - l4_pos;
					if (rel < PW'(2)) begin
						frame_nxt.port_a = {frame_q.port_a[7:0], data};
					end else if (rel < PW'(4)) begin
						frame_nxt.port_b = {frame_q.port_b[7:0], data};
					end else if (frame_q.proto == eip_pkg::PROTO_TCP) begin
						if (rel == PW'(12)) begin
							frame_nxt.l4_len_word = {8'h00, data};
						end else if (rel == PW'(13)) begin
							frame_nxt.flag = data;
						end
					end else if (rel < PW'(6)) begin
						frame_nxt.l4_len_word = {frame_q.l4_len_word[7:0], data};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			count_q <= '0;
		end else if (step) begin
			if (last) begin
				frame_q <= '0;
				count_q <= '0;
			end else begin
				frame_q <= frame_nxt;
				count_q <= count_nxt;
			end
		end
	end

endmodule

[rtl/eip_summary.sv]
// ----------------------------------------------------------------------------
// Frame summary
// Turns the captured header fields and the byte count of a closed frame into
// one result item: status, header fields, payload offset and payload length.
// ----------------------------------------------------------------------------
module eip_summary #(
	parameter int unsigned CNT_W = $clog2(eip_pkg::MAX_CAPTURE_DEF + 1)
) (
	input  eip_pkg::frame_t  frame,
	input  logic [CNT_W-1:0] count,
	output eip_pkg::result_t result
);

	localparam int unsigned WW = (CNT_W > 16) ? CNT_W : 16;

	always_comb begin
		logic [WW-1:0] len;
		logic [WW-1:0] avail;
		logic [WW-1:0] decl;
		logic [7:0]    hdr;
		logic [7:0]    ihl;
		logic [7:0]    l4_off;
		logic [7:0]    th;
		logic [7:0]    ip_l4;
		logic          ok;
		len = WW'(count);
		hdr = frame.tag_seen ? eip_pkg::VLAN_HDR : eip_pkg::ETH_HDR;
		ihl = {2'b00, frame.version_ihl[3:0], 2'b00};
		l4_off = hdr + ihl;
		th = {2'b00, frame.l4_len_word[7:4], 2'b00};
		ip_l4 = '0;
		decl = '0;
		ok = 1'b0;
		result = '0;
		if (len < WW'(eip_pkg::ETH_HDR)) begin
			result.status = eip_pkg::ST_SHORT_ETH;
		end else if (frame.tag_seen && len < WW'(eip_pkg::VLAN_HDR)) begin
			result.status = eip_pkg::ST_SHORT_VLAN;
			result.l2_type = frame.frame_type;
		end else begin
			result.l2_type = frame.frame_type;
			if (frame.frame_type == eip_pkg::TYPE_IPV4) begin
				if (len < WW'(hdr) + WW'(eip_pkg::IP_MIN_HDR)) begin
					result.status = eip_pkg::ST_SHORT_IP;
				end else if (frame.version_ihl[7:4] != 4'd4) begin
					result.status = eip_pkg::ST_NOT_V4;
				end else if (ihl < eip_pkg::IP_MIN_HDR || len < WW'(l4_off)) begin
					result.status = eip_pkg::ST_BAD_IHL;
				end else begin
					result.ip_protocol = frame.proto;
					result.source_addr = frame.src;
					result.dest_addr = frame.dst;
					if (frame.proto == eip_pkg::PROTO_TCP) begin
						ip_l4 = ihl + th;
						if (len < WW'(l4_off) + WW'(eip_pkg::TCP_MIN_HDR)) begin
							result.status = eip_pkg::ST_SHORT_L4;
						end else if (th < eip_pkg::TCP_MIN_HDR || len < WW'(l4_off) + WW'(th)) begin
							result.status = eip_pkg::ST_BAD_TCP_OFF;
						end else begin
							ok = 1'b1;
							result.source_port = frame.port_a;
							result.dest_port = frame.port_b;
							result.tcp_flag_bits = frame.flag;
							result.payload_offset = l4_off + th;
							if (frame.ip_total_len > {8'h00, ip_l4}) begin
								decl = WW'(frame.ip_total_len - {8'h00, ip_l4});
							end
						end
					end else if (frame.proto == eip_pkg::PROTO_UDP) begin
						if (len < WW'(l4_off) + WW'(eip_pkg::SMALL_L4_HDR)) begin
							result.status = eip_pkg::ST_SHORT_L4;
						end else if (frame.l4_len_word < {8'h00, eip_pkg::SMALL_L4_HDR}) begin
							result.status = eip_pkg::ST_BAD_UDP_LEN;
						end else begin
							ok = 1'b1;
							result.source_port = frame.port_a;
							result.dest_port = frame.port_b;
							result.payload_offset = l4_off + eip_pkg::SMALL_L4_HDR;
							decl = WW'(frame.l4_len_word - {8'h00, eip_pkg::SMALL_L4_HDR});
						end
					end else if (frame.proto == eip_pkg::PROTO_ICMP) begin
						ip_l4 = ihl + eip_pkg::SMALL_L4_HDR;
						if (len < WW'(l4_off) + WW'(eip_pkg::SMALL_L4_HDR)) begin
							result.status = eip_pkg::ST_SHORT_L4;
						end else begin
							ok = 1'b1;
							result.icmp_kind = frame.port_a;
							result.payload_offset = l4_off + eip_pkg::SMALL_L4_HDR;
							if (frame.ip_total_len >= {8'h00, ip_l4}) begin
								decl = WW'(frame.ip_total_len - {8'h00, ip_l4});
							end
						end
					end else begin
						result.status = eip_pkg::ST_OTHER_PROTO;
					end
				end
			end else if (frame.frame_type == eip_pkg::TYPE_ARP) begin
				result.status = (len < WW'(hdr) + WW'(eip_pkg::ARP_MIN)) ?
				                eip_pkg::ST_SHORT_ARP : eip_pkg::ST_ARP;
			end else begin
				result.status = eip_pkg::ST_OTHER_TYPE;
			end
		end
		avail = len - WW'(result.payload_offset);
		if (ok) begin
			result.status = eip_pkg::ST_L4_OK;
			result.payload_length = (avail < decl) ? avail[15:0] : decl[15:0];
		end
	end

endmodule

[rtl/ethernet_ipv4_header_parser.sv]
// ----------------------------------------------------------------------------
// Ethernet IPv4 header parser
// Parses a captured frame byte by byte and reports one summary per frame.
// ----------------------------------------------------------------------------
// The input stream carries one frame byte per item in tdata, in wire order,
// with tlast on the final captured byte of the frame. One VLAN or QinQ tag is
// skipped, the IPv4 header is checked, and the TCP, UDP or ICMP header words
// are captured. Bytes beyond MAX_CAPTURE are dropped, but tlast still closes
// the frame.
// The output stream carries one summary item per frame and nothing else.
// The input takes one byte per cycle while no final byte is held back. A byte
// is registered, then folded into the capture registers; on the final byte the
// captured fields are copied to a snapshot register, and the summary logic
// loads the output register from it.
// Reset clears the capture registers and all valid flags; no frame is in progress.
// When the receiver stalls, bytes of the next frame keep flowing in; only
// its final byte waits while both the snapshot and the output are full.
// ----------------------------------------------------------------------------
module ethernet_ipv4_header_parser #(
	parameter int unsigned MAX_CAPTURE = eip_pkg::MAX_CAPTURE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,  // data_byte
	input  logic                       s_axis_tlast,  // last_byte
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [eip_pkg::OUT_W-1:0]  m_axis_tdata   // status, l2_type,
	// ip_protocol, source_addr, dest_addr, source_port, dest_port,
	// tcp_flag_bits, icmp_kind, payload_offset, payload_length, zero pad
);

	localparam int unsigned CNT_W = $clog2(MAX_CAPTURE + 1);

	logic             valid_s1;
	logic             last_s1;
	logic [7:0]       data_s1;
	logic             valid_s2;
	eip_pkg::frame_t  frame_s2;
	logic [CNT_W-1:0] count_s2;
	logic             out_valid_q;
	eip_pkg::result_t result_q;

	eip_pkg::frame_t  frame_nxt;
	logic [CNT_W-1:0] count_nxt;
	eip_pkg::result_t result_nxt;

	logic out_free;
	logic s2_free;
	logic s1_step;

	assign out_free = !out_valid_q || m_axis_tready;
	assign s2_free = !valid_s2 || out_free;
	assign s1_step = valid_s1 && (!last_s1 || s2_free);
	assign s_axis_tready = !valid_s1 || s1_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	eip_capture #(
		.MAX_CAPTURE(MAX_CAPTURE),
		.CNT_W(CNT_W)
	) u_capture (
		.clk(clk),
		.arst_n(arst_n),
		.step(s1_step),
		.last(last_s1),
		.data(data_s1),
		.frame_nxt(frame_nxt),
		.count_nxt(count_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_step && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_step && last_s1) begin
			frame_s2 <= frame_nxt;
			count_s2 <= count_nxt;
		end
	end

	eip_summary #(
		.CNT_W(CNT_W)
	) u_summary (
		.frame(frame_s2),
		.count(count_s2),
		.result(result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			result_q <= result_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(eip_pkg::OUT_W - $bits(eip_pkg::result_t)){1'b0}}, result_q};

`ifndef SYNTHESIS
	a_result_from_snapshot: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s2))
		else $error("summary appeared without a closed frame");

	a_snapshot_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_free) |=> valid_s2)
		else $error("snapshot lost while output stalled");

	a_last_byte_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && !s2_free) |=> (valid_s1 && last_s1))
		else $error("final byte dropped while snapshot was full");
`endif

endmodule
